[hdl/aipm_pkg.sv]
// Shared types and operation codes for the allowed-address peer match table.
package aipm_pkg;

   localparam int unsigned PEER_W = 3;
   localparam int unsigned ASLOT_W = 2;
   localparam int unsigned HALF_W = 64;
   localparam int unsigned V4_W = 32;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_WRITE_SLOT = 2'd1;
   localparam logic [1:0] OP_WRITE_PEER = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [PEER_W-1:0]   peer_slot;
      logic [ASLOT_W-1:0]  addr_slot;
      logic                valid_bit;
      logic                is_v6;
      logic [HALF_W-1:0]   addr_upper;
      logic [HALF_W-1:0]   addr_lower;
      logic [HALF_W-1:0]   mask_upper;
      logic [HALF_W-1:0]   mask_lower;
   } aipm_req_type;

   typedef struct packed {
      logic                found;
      logic [PEER_W-1:0]   peer_found;
   } aipm_rsp_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic                slot_we;
      logic                peer_we;
      logic [PEER_W-1:0]   peer_slot;
      logic [ASLOT_W-1:0]  addr_slot;
      logic                valid_bit;
      logic                is_v6;
      logic [HALF_W-1:0]   addr_upper;
      logic [HALF_W-1:0]   addr_lower;
      logic [HALF_W-1:0]   mask_upper;
      logic [HALF_W-1:0]   mask_lower;
   } aipm_wr_type;

   // Lookup key and running result passed from cell to cell.
   typedef struct packed {
      logic                active;
      logic                is_v6;
      logic [HALF_W-1:0]   key_upper;
      logic [HALF_W-1:0]   key_lower;
      logic                found;
      logic [PEER_W-1:0]   peer_found;
   } aipm_token_type;

endpackage

[hdl/allowed_ip_peer_match.sv]
// Top level of the allowed-address peer match table: request/response control and cell chain.
//
// Usage:
//   req_ carries one transaction: a lookup, a slot write or a peer valid write.
//   rsp_ returns exactly one transaction per request: found and peer_found for a
//   lookup (first valid peer in ascending order with a valid slot of the key's
//   family whose masked address equals the masked key), all zero for writes.
// Structure:
//   One cell per peer, chained. A lookup key enters cell 0 and advances one cell
//   per cycle; each cell compares the key against its own slots and marks the
//   token unless an earlier cell already did.
// Ordering:
//   A lookup passes the registered token of every cell in turn, then the response
//   register; a write goes straight to the response register. One transaction is
//   in flight at a time, and a lookup holds the block until it leaves the chain.
// Reset:
//   Clears every peer and slot valid bit, the chain's active bits and the response
//   valid flag; the block takes a request in the first cycle after reset.
// Stall:
//   rsp_stall holds the response register; req_stall rises while a lookup walks
//   the chain or while a held response still waits to be taken.
module allowed_ip_peer_match
   import aipm_pkg::*;
#(
   parameter int unsigned PEER_COUNT = 8,
   parameter int unsigned SLOTS_PER_PEER = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  aipm_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output aipm_rsp_type rsp_data
);

   logic           busy_ff;
   logic           busy_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   aipm_rsp_type   rsp_data_ff;
   aipm_rsp_type   rsp_data_in;

   logic           req_fire;
   logic           rsp_take;
   logic           is_lookup;
   logic           chain_done;
   aipm_wr_type    wr;
   aipm_token_type chain [PEER_COUNT+1];

   // Hold requests while a lookup walks or a response is stuck downstream.
   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign is_lookup = (req_data.operation == OP_LOOKUP);

   // Broadcast table updates to all cells; each cell decodes its own index.
   always_comb begin
      wr.slot_we    = req_fire && (req_data.operation == OP_WRITE_SLOT);
      wr.peer_we    = req_fire && (req_data.operation == OP_WRITE_PEER);
      wr.peer_slot  = req_data.peer_slot;
      wr.addr_slot  = req_data.addr_slot;
      wr.valid_bit  = req_data.valid_bit;
      wr.is_v6      = req_data.is_v6;
      wr.addr_upper = req_data.addr_upper;
      wr.addr_lower = req_data.addr_lower;
      wr.mask_upper = req_data.mask_upper;
      wr.mask_lower = req_data.mask_lower;
   end

   // Inject the lookup key at the head of the chain.
   always_comb begin
      chain[0].active     = req_fire && is_lookup;
      chain[0].is_v6      = req_data.is_v6;
      chain[0].key_upper  = req_data.addr_upper;
      chain[0].key_lower  = req_data.addr_lower;
      chain[0].found      = 1'b0;
      chain[0].peer_found = '0;
   end

   for (genvar p = 0; p < PEER_COUNT; p++) begin : g_cell
      aipm_cell #(
         .SLOTS_PER_PEER (SLOTS_PER_PEER),
         .CELL_INDEX     (p)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr         (wr),
         .token_prev (chain[p]),
         .token_next (chain[p+1])
      );
   end

   assign chain_done = chain[PEER_COUNT].active;

   // Load the response from the chain tail or from a write; drop it once taken.
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (chain_done) begin
         busy_in                = 1'b0;
         rsp_valid_in           = 1'b1;
         rsp_data_in.found      = chain[PEER_COUNT].found;
         rsp_data_in.peer_found = chain[PEER_COUNT].found ?
                                  chain[PEER_COUNT].peer_found : '0;
      end else if (req_fire) begin
         if (is_lookup) begin
            busy_in = 1'b1;
         end else begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.found      = 1'b0;
            rsp_data_in.peer_found = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/aipm_cell.sv]
// One peer of the table: its valid bit, its slots and one stage of the lookup chain.
module aipm_cell
   import aipm_pkg::*;
#(
   parameter int unsigned SLOTS_PER_PEER = 4,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  aipm_wr_type    wr,
   input  aipm_token_type token_prev,
   output aipm_token_type token_next
);

   localparam logic [PEER_W-1:0] CELL_TAG = PEER_W'(CELL_INDEX);

   logic                peer_valid_ff;
   logic                slot_valid_ff [SLOTS_PER_PEER];
   logic                slot_v6_ff    [SLOTS_PER_PEER];
   logic [HALF_W-1:0]   addr_upper_ff [SLOTS_PER_PEER];
   logic [HALF_W-1:0]   addr_lower_ff [SLOTS_PER_PEER];
   logic [HALF_W-1:0]   mask_upper_ff [SLOTS_PER_PEER];
   logic [HALF_W-1:0]   mask_lower_ff [SLOTS_PER_PEER];

   logic                peer_sel;
   logic [SLOTS_PER_PEER-1:0] slot_we;
   logic [SLOTS_PER_PEER-1:0] slot_hit;
   aipm_token_type      token_ff;
   aipm_token_type      token_in;

   assign peer_sel = (32'(wr.peer_slot) == CELL_INDEX);

   always_comb begin
      logic [HALF_W-1:0] diff_lo;
      logic [HALF_W-1:0] diff_hi;
      for (int k = 0; k < SLOTS_PER_PEER; k++) begin
         slot_we[k] = wr.slot_we && peer_sel && (32'(wr.addr_slot) == k);
         diff_lo = (token_prev.key_lower ^ addr_lower_ff[k]) & mask_lower_ff[k];
         diff_hi = (token_prev.key_upper ^ addr_upper_ff[k]) & mask_upper_ff[k];
         if (!slot_valid_ff[k] || (slot_v6_ff[k] != token_prev.is_v6)) begin
            slot_hit[k] = 1'b0;
         end else if (token_prev.is_v6) begin
            slot_hit[k] = (diff_lo == '0) && (diff_hi == '0);
         end else begin
            slot_hit[k] = (diff_lo[V4_W-1:0] == '0);
         end
      end
   end

   // Keep an earlier peer's hit; claim the token only when still unmatched.
   always_comb begin
      token_in = token_prev;
      if (!token_prev.found && peer_valid_ff && (|slot_hit)) begin
         token_in.found = 1'b1;
         token_in.peer_found = CELL_TAG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_valid_ff <= 1'b0;
         token_ff.active <= 1'b0;
         for (int k = 0; k < SLOTS_PER_PEER; k++) begin
            slot_valid_ff[k] <= 1'b0;
         end
      end else begin
         if (wr.peer_we && peer_sel) begin
            peer_valid_ff <= wr.valid_bit;
         end
         token_ff <= token_in;
         for (int k = 0; k < SLOTS_PER_PEER; k++) begin
            if (slot_we[k]) begin
               slot_valid_ff[k] <= wr.valid_bit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS_PER_PEER; k++) begin
         if (slot_we[k]) begin
            slot_v6_ff[k]    <= wr.is_v6;
            addr_upper_ff[k] <= wr.addr_upper;
            addr_lower_ff[k] <= wr.addr_lower;
            mask_upper_ff[k] <= wr.mask_upper;
            mask_lower_ff[k] <= wr.mask_lower;
         end
      end
   end

   assign token_next = token_ff;

endmodule

[bench/aipm_checker.sv]
// Checker for the allowed-address peer match table: shadow table, route prediction, response compare.
module aipm_checker
   import aipm_pkg::*;
#(
   parameter int unsigned PEER_COUNT = 8,
   parameter int unsigned SLOTS_PER_PEER = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  aipm_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  aipm_rsp_type rsp_data,
   output int unsigned  mismatch_count,
   output int unsigned  pending_count
);

   localparam int unsigned SLOT_COUNT = PEER_COUNT * SLOTS_PER_PEER;

   bit                peer_live [PEER_COUNT];
   bit                slot_live [SLOT_COUNT];
   bit                slot_is_v6 [SLOT_COUNT];
   bit [2*HALF_W-1:0] slot_addr [SLOT_COUNT];
   bit [2*HALF_W-1:0] slot_mask [SLOT_COUNT];
   aipm_rsp_type      route_q [$];
   int unsigned       errors = 0;

   // First live peer, then first live slot of the key's family whose masked address fits.
   function automatic aipm_rsp_type route_for(aipm_req_type t);
      aipm_rsp_type      r;
      bit [2*HALF_W-1:0] diff;
      bit                hit;
      int unsigned       s;
      r = '0;
      for (int p = 0; p < PEER_COUNT; p++) begin
         for (int k = 0; k < SLOTS_PER_PEER; k++) begin
            s = p * SLOTS_PER_PEER + k;
            diff = ({t.addr_upper, t.addr_lower} ^ slot_addr[s]) & slot_mask[s];
            hit = t.is_v6 ? (diff == '0) : (diff[V4_W-1:0] == '0);
            if (!r.found && peer_live[p] && slot_live[s] && slot_is_v6[s] == t.is_v6 && hit) begin
               r.found = 1'b1;
               r.peer_found = PEER_W'(p);
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      aipm_rsp_type want;
      int unsigned  s;
      if (reset) begin
         foreach (peer_live[i]) peer_live[i] = 1'b0;
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_is_v6[i] = 1'b0;
            slot_addr[i] = '0;
            slot_mask[i] = '0;
         end
         route_q.delete();
      end else begin
         // Retire the response first so a request in the same cycle cannot be matched to it.
         if (rsp_valid && !rsp_stall) begin
            if (route_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: response with nothing outstanding: found=%0b peer=%0d",
                           rsp_data.found, rsp_data.peer_found);
            end else begin
               want = route_q.pop_front();
               if (rsp_data.found !== want.found || rsp_data.peer_found !== want.peer_found) begin
                  errors++;
                  if (errors <= 10)
                     $display("ERROR: route mismatch: found exp %0b got %0b, peer exp %0d got %0d",
                              want.found, rsp_data.found, want.peer_found, rsp_data.peer_found);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (req_data.operation)
               OP_LOOKUP: want = route_for(req_data);
               OP_WRITE_SLOT: begin
                  if (req_data.peer_slot < PEER_COUNT && req_data.addr_slot < SLOTS_PER_PEER) begin
                     s = req_data.peer_slot * SLOTS_PER_PEER + req_data.addr_slot;
                     slot_live[s] = req_data.valid_bit;
                     slot_is_v6[s] = req_data.is_v6;
                     slot_addr[s] = {req_data.addr_upper, req_data.addr_lower};
                     slot_mask[s] = {req_data.mask_upper, req_data.mask_lower};
                  end
               end
               OP_WRITE_PEER: begin
                  if (req_data.peer_slot < PEER_COUNT)
                     peer_live[req_data.peer_slot] = req_data.valid_bit;
               end
               default: ;
            endcase
            route_q.push_back(want);
         end
      end
      mismatch_count <= errors;
      pending_count <= route_q.size();
   end

endmodule

[bench/tb_allowed_ip_peer_match.sv]
// Testbench top for the allowed-address peer match table: stimulus, handshake pacing, verdict.
module tb_allowed_ip_peer_match;
   import aipm_pkg::*;

   localparam int unsigned PEER_COUNT = 8;
   localparam int unsigned SLOTS_PER_PEER = 4;
   localparam int unsigned SLOT_COUNT = PEER_COUNT * SLOTS_PER_PEER;
   localparam int unsigned RANDOM_ITEMS = 750;
   // Bound on the whole run, well above what the slowest legal run needs.
   localparam int unsigned CYCLE_LIMIT = 500000;
   // Operation code the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   aipm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   aipm_rsp_type rsp_data;
   int unsigned  mismatch_count;
   int unsigned  pending_count;
   int unsigned  cycle_count = 0;
   int unsigned  quiet_left = 0;

   // What each slot was last loaded with, so lookups can be aimed at real entries.
   logic [2*HALF_W-1:0] aim_addr [SLOT_COUNT];
   logic [2*HALF_W-1:0] aim_mask [SLOT_COUNT];
   logic                aim_v6 [SLOT_COUNT];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   allowed_ip_peer_match #(
      .PEER_COUNT(PEER_COUNT),
      .SLOTS_PER_PEER(SLOTS_PER_PEER)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   aipm_checker #(
      .PEER_COUNT(PEER_COUNT),
      .SLOTS_PER_PEER(SLOTS_PER_PEER)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   function automatic logic [HALF_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Fully random transaction; every field, including the unused operation code.
   function automatic aipm_req_type noise_item();
      aipm_req_type t;
      t.operation = 2'($urandom_range(0, 3));
      t.peer_slot = PEER_W'($urandom_range(0, (1 << PEER_W) - 1));
      t.addr_slot = ASLOT_W'($urandom_range(0, (1 << ASLOT_W) - 1));
      t.valid_bit = 1'($urandom_range(0, 1));
      t.is_v6 = 1'($urandom_range(0, 1));
      t.addr_upper = rand64();
      t.addr_lower = rand64();
      t.mask_upper = rand64();
      t.mask_lower = rand64();
      return t;
   endfunction

   // Prefix of len bits at the top of the family's address. For IPv4 only the low
   // word counts, so fill everything above it with junk the compare must ignore.
   function automatic logic [2*HALF_W-1:0] prefix_mask(logic v6, int unsigned len);
      logic [2*HALF_W-1:0] m;
      logic [V4_W-1:0]     m4;
      m = '1;
      m4 = '1;
      if (v6) begin
         m = m << (2*HALF_W - len);
      end else begin
         m4 = m4 << (V4_W - len);
         m = {rand64(), rand64()};
         m[V4_W-1:0] = m4;
      end
      return m;
   endfunction

   function automatic aipm_req_type slot_write(int unsigned peer, int unsigned aslot, logic valid,
                                                logic v6, logic [2*HALF_W-1:0] addr,
                                                logic [2*HALF_W-1:0] mask);
      aipm_req_type t;
      t.operation = OP_WRITE_SLOT;
      t.peer_slot = PEER_W'(peer);
      t.addr_slot = ASLOT_W'(aslot);
      t.valid_bit = valid;
      t.is_v6 = v6;
      {t.addr_upper, t.addr_lower} = addr;
      {t.mask_upper, t.mask_lower} = mask;
      return t;
   endfunction

   // Fields a peer write ignores carry random junk.
   function automatic aipm_req_type peer_write(int unsigned peer, logic valid);
      aipm_req_type t;
      t = noise_item();
      t.operation = OP_WRITE_PEER;
      t.peer_slot = PEER_W'(peer);
      t.valid_bit = valid;
      return t;
   endfunction

   function automatic aipm_req_type lookup(logic v6, logic [2*HALF_W-1:0] key);
      aipm_req_type t;
      t = noise_item();
      t.operation = OP_LOOKUP;
      t.is_v6 = v6;
      {t.addr_upper, t.addr_lower} = key;
      return t;
   endfunction

   // Present one transaction, hold it until accepted, then idle for a random gap.
   // Gaps are mostly short, sometimes long, with occasional stretches of none.
   task automatic send_txn(aipm_req_type t);
      int unsigned s;
      int unsigned pick;
      int unsigned gap;
      if (t.operation == OP_WRITE_SLOT) begin
         s = t.peer_slot * SLOTS_PER_PEER + t.addr_slot;
         aim_addr[s] = {t.addr_upper, t.addr_lower};
         aim_mask[s] = {t.mask_upper, t.mask_lower};
         aim_v6[s] = t.is_v6;
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pick = $urandom_range(0, 99);
      if (quiet_left != 0) begin
         quiet_left--;
         gap = 0;
      end else if (pick < 2) begin
         quiet_left = 60;
         gap = 0;
      end else if (pick < 55) begin
         gap = 0;
      end else if (pick < 88) begin
         gap = $urandom_range(1, 3);
      end else if (pick < 97) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 40);
      end
      // Keep valid high across back-to-back transactions; drop it only for a real gap.
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: ready runs broken by stalls, mostly short, a few long,
   // and now and then a long stall-free stretch.
   initial begin
      int unsigned run;
      int unsigned hold;
      int unsigned pick;
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         run = (pick < 5) ? 150 : $urandom_range(1, 8);
         pick = $urandom_range(0, 99);
         if (pick < 75) hold = $urandom_range(1, 3);
         else if (pick < 95) hold = $urandom_range(4, 10);
         else hold = $urandom_range(20, 40);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      aipm_req_type        item;
      int unsigned         pick;
      int unsigned         s;
      int unsigned         len;
      logic                v6;
      logic [2*HALF_W-1:0] key;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Load every slot once, all invalid, so no lookup ever compares unwritten data.
      for (int n = 0; n < SLOT_COUNT; n++) begin
         v6 = 1'($urandom_range(0, 1));
         send_txn(slot_write(n / SLOTS_PER_PEER, n % SLOTS_PER_PEER, 1'b0, v6,
                             {rand64(), rand64()},
                             prefix_mask(v6, $urandom_range(0, v6 ? 2*HALF_W : V4_W))));
      end

      // Directed part.
      // No live peer yet: nothing may match.
      send_txn(lookup(1'b0, '0));
      // All-ones transaction carries the unused operation code: no effect, zero result.
      item = '1;
      send_txn(item);
      item.operation = OP_UNUSED;
      item.valid_bit = 1'b0;
      item.peer_slot = '0;
      send_txn(item);
      // Exact IPv6 host entry on the last peer, seen only once the peer goes live.
      send_txn(slot_write(PEER_COUNT - 1, SLOTS_PER_PEER - 1, 1'b1, 1'b1, '1, '1));
      send_txn(lookup(1'b1, '1));
      send_txn(peer_write(PEER_COUNT - 1, 1'b1));
      send_txn(lookup(1'b1, '1));
      // One bit off, and the wrong family: both miss.
      send_txn(lookup(1'b1, ~{{(2*HALF_W-1){1'b0}}, 1'b1}));
      send_txn(lookup(1'b0, '1));
      // Empty-prefix IPv4 entry on peer 0 catches any IPv4 key, and no IPv6 key.
      send_txn(slot_write(0, 0, 1'b1, 1'b0, {rand64(), rand64()}, prefix_mask(1'b0, 0)));
      send_txn(peer_write(0, 1'b1));
      send_txn(lookup(1'b0, {rand64(), rand64()}));
      send_txn(lookup(1'b1, '1));
      // IPv6 host entry for the all-zero address on peer 3.
      send_txn(slot_write(3, 2, 1'b1, 1'b1, '0, '1));
      send_txn(peer_write(3, 1'b1));
      send_txn(lookup(1'b1, '0));
      // Retire the IPv4 catch-all.
      send_txn(slot_write(0, 0, 1'b0, 1'b0, '0, '0));
      send_txn(lookup(1'b0, '0));
      // IPv4 host entry with a full mask: bits above the low word must not count,
      // bit 31 must.
      send_txn(slot_write(5, 1, 1'b1, 1'b0, {96'h0, 32'hC0A8_0001}, '1));
      send_txn(peer_write(5, 1'b1));
      send_txn(lookup(1'b0, {64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF, 32'hC0A8_0001}));
      send_txn(lookup(1'b0, {96'h0, 32'h40A8_0001}));
      // First match wins over a longer prefix: an IPv6 catch-all on peer 2 hides
      // the host entries on later peers until peer 2 is switched off.
      send_txn(slot_write(2, 3, 1'b1, 1'b1, '1, '0));
      send_txn(peer_write(2, 1'b1));
      send_txn(lookup(1'b1, '1));
      send_txn(peer_write(2, 1'b0));
      send_txn(lookup(1'b1, '0));

      // Random part: mostly lookups aimed at loaded entries, plus table churn and noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            // Hold off until every outstanding transaction has been answered.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            v6 = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
               0: len = 0;
               1: len = v6 ? 2*HALF_W : V4_W;
               default: len = $urandom_range(0, v6 ? 2*HALF_W : V4_W);
            endcase
            item = slot_write($urandom_range(0, PEER_COUNT - 1),
                              $urandom_range(0, SLOTS_PER_PEER - 1),
                              $urandom_range(0, 9) != 0, v6, {rand64(), rand64()},
                              prefix_mask(v6, len));
         end else if (pick < 26) begin
            item = peer_write($urandom_range(0, PEER_COUNT - 1), $urandom_range(0, 3) != 0);
         end else if (pick < 32) begin
            item = noise_item();
         end else begin
            s = $urandom_range(0, SLOT_COUNT - 1);
            key = {rand64(), rand64()};
            if ($urandom_range(0, 4) != 0) begin
               // Keep the entry's cared-for bits, randomize the rest.
               key = (aim_addr[s] & aim_mask[s]) | (key & ~aim_mask[s]);
               v6 = aim_v6[s];
               // Flip one address bit now and then to force a near miss.
               if ($urandom_range(0, 6) == 0)
                  key[$urandom_range(0, v6 ? 2*HALF_W - 1 : V4_W - 1)] ^= 1'b1;
            end else begin
               v6 = 1'($urandom_range(0, 1));
            end
            item = lookup(v6, key);
         end
         send_txn(item);
      end

      // Drain: wait for every response, then give the block time to show stray ones.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4 * PEER_COUNT) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
